@@ hdl/kwm_pkg.sv @@
`timescale 1ns / 1ps

package kwm_pkg;

  // default geometry
  localparam int WAYS_DEF      = 8;
  localparam int WAY_DEPTH_DEF = 64;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // item kinds carried on in_tuser
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // packed stream widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PUSH = 5'b00010,
    S_PICK = 5'b00100,
    S_POP  = 5'b01000,
    S_FILL = 5'b10000
  } state_t;

endpackage

@@ hdl/k_way_sorted_merge_top.sv @@
`timescale 1ns / 1ps
// a push item passes S_PUSH, a pop item S_PICK and then S_POP, before its result is registered at the output;
// S_PUSH and S_POP wait while the output is held, and a pop also passes S_FILL when the popped
//   way still holds entries and its next head is fetched from the way store
// new items are taken only in S_IDLE; pop rate is set by the registered way store read and minimum tree
// reset (rst_n, synchronous, active low) empties every way; the way store is not cleared
// and needs no clearing pass, since only data read from filled slots is ever used
module k_way_sorted_merge_top #(
  parameter int WAYS      = kwm_pkg::WAYS_DEF,
  parameter int WAY_DEPTH = kwm_pkg::WAY_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input item channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [kwm_pkg::IN_TDATA_W-1:0]   in_tdata,   // way[2:0], value[34:3], zero pad
  input  logic                             in_tuser,   // op (0 push, 1 pop)
  // result item channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [kwm_pkg::OUT_TDATA_W-1:0]  out_tdata,  // result_value[31:0], source_way[34:32], zero pad
  output logic [1:0]                       out_tuser   // status
);
  import kwm_pkg::*;

  // widths follow from the geometry
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;            // way index
  localparam int HW = (WAY_DEPTH > 1) ? $clog2(WAY_DEPTH) : 1;  // slot index
  localparam int CW = $clog2(WAY_DEPTH + 1);                    // fill count
  localparam int SW = CW + 1;                                   // head + fill sum
  localparam int MD = WAYS * WAY_DEPTH;                         // way store depth
  localparam int AW = $clog2(MD);
  localparam int LV = $clog2(WAYS);                             // minimum tree levels
  localparam int NP = 1 << LV;

  // control state
  state_t          state_r, state_nxt;

  // captured item
  logic [2:0]      way_r, way_nxt;
  logic [31:0]     val_r, val_nxt;

  // per-way bookkeeping, cleared at reset
  logic [HW-1:0]   head_idx_r [WAYS];
  logic [CW-1:0]   fill_r     [WAYS];
  logic [WAYS-1:0] nonempty_r;

  // cached head value of every way (valid where nonempty_r is set)
  logic [31:0]     head_val_r [WAYS];

  // way store: one synchronous memory, one write and one read per cycle
  logic [31:0]     store_mem [MD];
  logic [31:0]     rd_data_r;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;

  // pop winner
  logic [WW-1:0]   best_r, best_nxt;
  logic [31:0]     best_val_r, best_val_nxt;
  logic            found_r, found_nxt;

  // output register
  logic            out_valid_r, out_valid_nxt;
  logic [31:0]     out_val_r, out_val_nxt;
  logic [2:0]      out_src_r, out_src_nxt;
  logic [1:0]      out_st_r, out_st_nxt;
  logic            out_free;

  // bookkeeping strobes
  logic            cnt_we;
  logic [HW-1:0]   head_wr;
  logic [CW-1:0]   fill_wr;
  logic            hv_we;
  logic [31:0]     hv_data;
  logic            ne_set, ne_clr;

  // selected way and its counters
  logic [31:0]     way_ext;
  logic            way_ok;
  logic [WW-1:0]   sel;
  logic [HW-1:0]   sel_head;
  logic [CW-1:0]   sel_fill;
  logic [AW-1:0]   sel_base;
  logic [SW-1:0]   tail_sum;
  logic [HW-1:0]   tail;
  logic [HW-1:0]   head_inc;
  logic [31:0]     best_ext;

  // minimum tree
  logic [31:0]     t_val [LV+1][NP];
  logic [WW-1:0]   t_way [LV+1][NP];
  logic            t_ok  [LV+1][NP];

  // a push may name a way that does not exist in narrow configurations
  assign way_ext  = 32'(way_r);
  assign way_ok   = (way_ext < 32'(WAYS));
  assign sel      = ((state_r == S_POP) || (state_r == S_FILL)) ? best_r : way_ext[WW-1:0];
  assign sel_head = head_idx_r[sel];
  assign sel_fill = fill_r[sel];
  assign sel_base = AW'(sel) * AW'(WAY_DEPTH);

  // tail slot, head + fill stays below twice the depth
  assign tail_sum = SW'(sel_head) + SW'(sel_fill);
  assign tail     = (tail_sum >= SW'(WAY_DEPTH)) ? HW'(tail_sum - SW'(WAY_DEPTH)) : HW'(tail_sum);
  assign head_inc = (sel_head == HW'(WAY_DEPTH - 1)) ? '0 : HW'(sel_head + HW'(1));

  assign mem_waddr = sel_base + AW'(tail);
  assign mem_raddr = sel_base + AW'(head_inc);

  assign best_ext  = 32'(best_r);

  // minimum tree over the cached heads, lower way wins a tie
  genvar gi, gl, gn;
  generate
    for (gi = 0; gi < NP; gi++) begin : g_leaf
      if (gi < WAYS) begin : g_used
        assign t_val[0][gi] = head_val_r[gi];
        assign t_way[0][gi] = WW'(gi);
        assign t_ok[0][gi]  = nonempty_r[gi];
      end else begin : g_pad
        assign t_val[0][gi] = '0;
        assign t_way[0][gi] = '0;
        assign t_ok[0][gi]  = 1'b0;
      end
    end
    for (gl = 0; gl < LV; gl++) begin : g_lvl
      for (gn = 0; gn < NP; gn++) begin : g_node
        if (gn < (NP >> (gl + 1))) begin : g_cmp
          logic take_right;
          assign take_right = t_ok[gl][2*gn+1] &&
                              (!t_ok[gl][2*gn] ||
                               ($signed(t_val[gl][2*gn+1]) < $signed(t_val[gl][2*gn])));
          assign t_val[gl+1][gn] = take_right ? t_val[gl][2*gn+1] : t_val[gl][2*gn];
          assign t_way[gl+1][gn] = take_right ? t_way[gl][2*gn+1] : t_way[gl][2*gn];
          assign t_ok[gl+1][gn]  = t_ok[gl][2*gn] | t_ok[gl][2*gn+1];
        end else begin : g_idle
          assign t_val[gl+1][gn] = '0;
          assign t_way[gl+1][gn] = '0;
          assign t_ok[gl+1][gn]  = 1'b0;
        end
      end
    end
  endgenerate

  // handshakes
  assign in_tready  = (state_r == S_IDLE);
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_src_r, out_val_r};
  assign out_tuser  = out_st_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    way_nxt       = way_r;
    val_nxt       = val_r;
    best_nxt      = best_r;
    best_val_nxt  = best_val_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_val_nxt   = out_val_r;
    out_src_nxt   = out_src_r;
    out_st_nxt    = out_st_r;
    mem_we        = 1'b0;
    cnt_we        = 1'b0;
    head_wr       = sel_head;
    fill_wr       = sel_fill;
    hv_we         = 1'b0;
    hv_data       = val_r;
    ne_set        = 1'b0;
    ne_clr        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          way_nxt   = in_tdata[2:0];
          val_nxt   = in_tdata[34:3];
          state_nxt = (in_tuser == OP_POP) ? S_PICK : S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = '0;
          out_src_nxt   = '0;
          if (!way_ok || (sel_fill == CW'(WAY_DEPTH))) begin
            out_st_nxt = ST_FULL;
          end else begin
            out_st_nxt = ST_OK;
            mem_we     = 1'b1;
            cnt_we     = 1'b1;
            fill_wr    = sel_fill + CW'(1);
            // first entry of an empty way becomes its head at once
            if (sel_fill == '0) begin
              hv_we  = 1'b1;
              ne_set = 1'b1;
            end
          end
          state_nxt = S_IDLE;
        end
      end
      S_PICK: begin
        best_nxt     = t_way[LV][0];
        best_val_nxt = t_val[LV][0];
        found_nxt    = t_ok[LV][0];
        state_nxt    = S_POP;
      end
      S_POP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (!found_r) begin
            out_val_nxt = '0;
            out_src_nxt = '0;
            out_st_nxt  = ST_EMPTY;
            state_nxt   = S_IDLE;
          end else begin
            out_val_nxt = best_val_r;
            out_src_nxt = best_ext[2:0];
            out_st_nxt  = ST_OK;
            cnt_we      = 1'b1;
            head_wr     = head_inc;
            fill_wr     = sel_fill - CW'(1);
            // next head comes back through the registered store read in S_FILL
            if (sel_fill > CW'(1)) begin
              state_nxt = S_FILL;
            end else begin
              ne_clr    = 1'b1;
              state_nxt = S_IDLE;
            end
          end
        end
      end
      S_FILL: begin
        hv_we     = 1'b1;
        hv_data   = rd_data_r;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    way_r      <= way_nxt;
    val_r      <= val_nxt;
    best_r     <= best_nxt;
    best_val_r <= best_val_nxt;
    found_r    <= found_nxt;
    out_val_r  <= out_val_nxt;
    out_src_r  <= out_src_nxt;
    out_st_r   <= out_st_nxt;
  end

  // per-way counters and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WAYS; i++) begin
        head_idx_r[i] <= '0;
        fill_r[i]     <= '0;
      end
      nonempty_r <= '0;
    end else begin
      if (cnt_we) begin
        head_idx_r[sel] <= head_wr;
        fill_r[sel]     <= fill_wr;
      end
      if (ne_set) begin
        nonempty_r[sel] <= 1'b1;
      end else if (ne_clr) begin
        nonempty_r[sel] <= 1'b0;
      end
    end
  end

  // head cache
  always_ff @(posedge clk) begin
    if (hv_we) begin
      head_val_r[sel] <= hv_data;
    end
  end

  // way store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= val_r;
    end
    rd_data_r <= store_mem[mem_raddr];
  end

  // a found winner must be an occupied way
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) && found_r |-> nonempty_r[best_r])
    else $error("pop winner is an empty way");

  // a head refill only follows a pop that left entries behind
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) |-> nonempty_r[best_r] && (fill_r[best_r] != '0))
    else $error("head refill for an emptied way");

  // occupancy flag and fill count agree for the selected way
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH) && way_ok |-> (nonempty_r[sel] == (sel_fill != '0)))
    else $error("occupancy flag out of step with fill count");

  // counts stay within the way depth while an item is being worked on
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (sel_fill <= CW'(WAY_DEPTH)))
    else $error("fill count beyond way depth");

  // a pop result leaves the pop state, the way it came from loses one entry
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) && found_r && out_free |=>
      (fill_r[$past(best_r)] == $past(sel_fill) - CW'(1)))
    else $error("popped way count not decremented");

endmodule
